// ===== src/sht_pkg.sv =====
// ----------------------------------------------------------------------------
// sht_pkg
// shared constants, types and the hysteresis compare of the thermostat
// ----------------------------------------------------------------------------
package sht_pkg;

   localparam int SLOTS_PER_DAY = 8;
   localparam int DAYS          = 7;

   localparam int SLOT_W    = (SLOTS_PER_DAY > 1) ? $clog2(SLOTS_PER_DAY) : 1;
   localparam int MEM_DEPTH = DAYS * (1 << SLOT_W);
   localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

   localparam int TEMP_W     = 15;
   localparam int TIME_W     = 12;
   localparam int BAND_W     = 11;
   localparam int AGE_W      = 32;
   localparam int LIMIT_W    = 16;
   localparam int DAY_W      = 3;
   localparam int HOUR_W     = 5;
   localparam int MIN_W      = 6;
   localparam int IDX_W      = 3;
   localparam int MODE_W     = 2;
   localparam int OUT_W      = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int CMP_W      = TEMP_W + 2;

   // minute * 100 / 60 == minute * 5 / 3, the divide by 3 by reciprocal
   localparam int MIN5_W     = MIN_W + 3;
   localparam int RECIP_W    = 10;
   localparam int MIN_RECIP  = 683;
   localparam int MIN_SHIFT  = 11;
   localparam int PROD_W     = MIN5_W + RECIP_W;
   localparam int HOUR_SCALE = 100;

   localparam logic KIND_EVAL  = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   localparam logic [MODE_W-1:0] MODE_MANUAL   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SCHEDULE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLED,
      CSR_MODE,
      CSR_SETPOINT,
      CSR_BAND_BELOW,
      CSR_BAND_ABOVE,
      CSR_STALE_LIMIT
   } csr_index_type;

   typedef enum logic [OUT_W-1:0] {
      OUT_HELD,
      OUT_ON_LOW,
      OUT_OFF_HIGH,
      OUT_STALE,
      OUT_INVALID,
      OUT_DISABLED,
      OUT_NO_SLOT,
      OUT_WRITTEN
   } outcome_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_WALK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                     active;
      logic [TIME_W-1:0]        start_time;
      logic [TIME_W-1:0]        end_time;
      logic signed [TEMP_W-1:0] setpoint;
   } slot_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      slot_type          data;
   } mem_wr_type;

   typedef struct packed {
      logic                     enabled;
      logic [MODE_W-1:0]        mode;
      logic signed [TEMP_W-1:0] manual_setpoint;
      logic [BAND_W-1:0]        band_below;
      logic [BAND_W-1:0]        band_above;
      logic [LIMIT_W-1:0]       stale_limit;
      logic                     relay_clear;
   } cfg_type;

   typedef struct packed {
      logic                     kind;
      logic signed [TEMP_W-1:0] temperature;
      logic                     sensor_active;
      logic [AGE_W-1:0]         sensor_age;
      logic [DAY_W-1:0]         day_of_week;
      logic [HOUR_W-1:0]        hour;
      logic [MIN_W-1:0]         minute;
      logic [IDX_W-1:0]         slot_index;
      logic                     slot_active;
      logic [TIME_W-1:0]        slot_start;
      logic [TIME_W-1:0]        slot_end;
      logic signed [TEMP_W-1:0] slot_setpoint;
   } item_type;

   function automatic outcome_type hyst_cmp(
      input logic signed [TEMP_W-1:0] temp,
      input logic signed [TEMP_W-1:0] setpoint,
      input logic [BAND_W-1:0]        below,
      input logic [BAND_W-1:0]        above
   );
      logic signed [CMP_W-1:0] t_x;
      logic signed [CMP_W-1:0] lo;
      logic signed [CMP_W-1:0] hi;
      t_x = CMP_W'(temp);
      lo  = CMP_W'(setpoint) - signed'(CMP_W'(below));
      hi  = CMP_W'(setpoint) + signed'(CMP_W'(above));
      if (t_x < lo) begin
         return OUT_ON_LOW;
      end else if (t_x > hi) begin
         return OUT_OFF_HIGH;
      end else begin
         return OUT_HELD;
      end
   endfunction

endpackage

// ===== src/sht_mem.sv =====
// ----------------------------------------------------------------------------
// sht_mem
// weekly slot store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module sht_mem
   import sht_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  mem_wr_type        wr,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output slot_type          rd_data
);

   slot_type               slot_mem_ff [MEM_DEPTH];
   logic [MEM_DEPTH-1:0]   vld_ff;
   slot_type               rd_ff;
   logic                   rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         slot_mem_ff[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_ff <= slot_mem_ff[rd_addr];
      end
   end

   // unwritten entries read as inactive
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            vld_ff[wr.addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   always_comb begin
      rd_data        = rd_ff;
      rd_data.active = rd_ff.active & rd_vld_ff;
   end

endmodule

// ===== src/sht_ctrl.sv =====
// ----------------------------------------------------------------------------
// sht_ctrl
// item sequencer: decision chain, slot walk over the store, relay and result
// ----------------------------------------------------------------------------
module sht_ctrl
   import sht_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              req_valid,
   output logic              req_stall,
   input  item_type          req_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_relay_on,
   output logic [OUT_W-1:0]  rsp_outcome,
   output mem_wr_type        mem_wr,
   output logic              mem_rd_en,
   output logic [ADDR_W-1:0] mem_rd_addr,
   input  slot_type          mem_rd_data
);

   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS_PER_DAY - 1);

   state_type          state_ff,   state_in;
   item_type           item_ff,    item_in;
   logic [TIME_W-1:0]  now_ff,     now_in;
   logic [SLOT_W-1:0]  k_ff,       k_in;
   logic               relay_ff,   relay_in;
   outcome_type        outcome_ff, outcome_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_relay_ff, rsp_relay_in;
   logic [OUT_W-1:0]   rsp_outcome_ff, rsp_outcome_in;

   logic               day_ok;
   logic               stale;
   logic               go_walk;
   logic               rsp_free;
   logic               slot_hit;
   logic [MIN5_W-1:0]  min5;
   logic [PROD_W-1:0]  min_prod;
   logic [TIME_W-1:0]  hour_units;
   outcome_type        manual_cmp;
   outcome_type        slot_cmp;

   assign day_ok   = 32'(item_ff.day_of_week) < DAYS;
   assign stale    = item_ff.sensor_age >= AGE_W'(cfg.stale_limit);
   assign go_walk  = (item_ff.kind == KIND_EVAL) && item_ff.sensor_active && cfg.enabled
                     && !stale && (cfg.mode == MODE_SCHEDULE) && day_ok;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   assign min5       = {item_ff.minute, 2'b00} + MIN5_W'(item_ff.minute);
   assign min_prod   = PROD_W'(min5) * PROD_W'(MIN_RECIP);
   assign hour_units = TIME_W'(item_ff.hour) * TIME_W'(HOUR_SCALE);

   assign slot_hit   = (now_ff >= mem_rd_data.start_time) && (now_ff < mem_rd_data.end_time);
   assign manual_cmp = hyst_cmp(item_ff.temperature, cfg.manual_setpoint,
                                cfg.band_below, cfg.band_above);
   assign slot_cmp   = hyst_cmp(item_ff.temperature, mem_rd_data.setpoint,
                                cfg.band_below, cfg.band_above);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = go_walk ? ST_WALK : ST_DONE;
         end
         ST_WALK: begin
            if (!mem_rd_data.active || (k_ff == SLOT_LAST)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall      = (state_ff != ST_IDLE);
      item_in        = item_ff;
      now_in         = now_ff;
      k_in           = k_ff;
      relay_in       = relay_ff;
      outcome_in     = outcome_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_relay_in   = rsp_relay_ff;
      rsp_outcome_in = rsp_outcome_ff;
      mem_wr         = '0;
      mem_rd_en      = 1'b0;
      mem_rd_addr    = ADDR_W'({item_ff.day_of_week, k_ff});
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in = req_item;
            end
         end
         ST_EXEC: begin
            now_in = hour_units + TIME_W'(min_prod >> MIN_SHIFT);
            k_in   = '0;
            if (item_ff.kind == KIND_WRITE) begin
               outcome_in                = OUT_WRITTEN;
               mem_wr.en                 = day_ok && (32'(item_ff.slot_index) < SLOTS_PER_DAY);
               mem_wr.addr               = ADDR_W'({item_ff.day_of_week,
                                                    SLOT_W'(item_ff.slot_index)});
               mem_wr.data.active        = item_ff.slot_active;
               mem_wr.data.start_time    = item_ff.slot_start;
               mem_wr.data.end_time      = item_ff.slot_end;
               mem_wr.data.setpoint      = item_ff.slot_setpoint;
            end else if (!item_ff.sensor_active) begin
               relay_in   = 1'b0;
               outcome_in = OUT_INVALID;
            end else if (!cfg.enabled) begin
               outcome_in = OUT_DISABLED;
            end else if (stale) begin
               relay_in   = 1'b0;
               outcome_in = OUT_STALE;
            end else if (cfg.mode == MODE_MANUAL) begin
               outcome_in = manual_cmp;
               if (manual_cmp == OUT_ON_LOW) begin
                  relay_in = 1'b1;
               end else if (manual_cmp == OUT_OFF_HIGH) begin
                  relay_in = 1'b0;
               end
            end else if (cfg.mode == MODE_SCHEDULE) begin
               outcome_in  = OUT_NO_SLOT;
               mem_rd_en   = day_ok;
               mem_rd_addr = ADDR_W'({item_ff.day_of_week, SLOT_W'(0)});
            end else begin
               outcome_in = OUT_HELD;
            end
         end
         ST_WALK: begin
            if (mem_rd_data.active) begin
               if (slot_hit) begin
                  outcome_in = slot_cmp;
                  if (slot_cmp == OUT_ON_LOW) begin
                     relay_in = 1'b1;
                  end else if (slot_cmp == OUT_OFF_HIGH) begin
                     relay_in = 1'b0;
                  end
               end
               if (k_ff != SLOT_LAST) begin
                  k_in        = k_ff + 1'b1;
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = ADDR_W'({item_ff.day_of_week, k_in});
               end
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_relay_in   = relay_ff;
               rsp_outcome_in = outcome_ff;
            end
         end
         default: begin
         end
      endcase
      if (cfg.relay_clear) begin
         relay_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         relay_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         relay_ff     <= relay_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff        <= item_in;
      now_ff         <= now_in;
      k_ff           <= k_in;
      outcome_ff     <= outcome_in;
      rsp_relay_ff   <= rsp_relay_in;
      rsp_outcome_ff <= rsp_outcome_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_relay_on = rsp_relay_ff;
   assign rsp_outcome  = rsp_outcome_ff;

endmodule

// ===== src/scheduled_hysteresis_thermostat.sv =====
// ----------------------------------------------------------------------------
// scheduled_hysteresis_thermostat
// heating relay control with hysteresis, manual or weekly schedule setpoint
// ----------------------------------------------------------------------------
//  channel  handshake              contents
//  req_     req_valid / req_stall  one evaluate or slot-write transaction
//  rsp_     rsp_valid / rsp_stall  relay drive and outcome code
//  csr_     csr_valid / csr_ready  register index and write data
//
//  slot write, manual mode and early exits go through exec and done to result
//  schedule mode walks the day's slots one per cycle through the store's read
//  port; one transaction is in work at a time
//  reset: slot store reads as all inactive at once, no clearing pass
//  a waiting result does not block the next accept; a stalled rsp_ holds the
//  sequencer in its last step until the output register frees
// ----------------------------------------------------------------------------
module scheduled_hysteresis_thermostat
   import sht_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_kind,
   input  logic signed [TEMP_W-1:0] req_temperature,
   input  logic                     req_sensor_active,
   input  logic [AGE_W-1:0]         req_sensor_age,
   input  logic [DAY_W-1:0]         req_day_of_week,
   input  logic [HOUR_W-1:0]        req_hour,
   input  logic [MIN_W-1:0]         req_minute,
   input  logic [IDX_W-1:0]         req_slot_index,
   input  logic                     req_slot_active,
   input  logic [TIME_W-1:0]        req_slot_start,
   input  logic [TIME_W-1:0]        req_slot_end,
   input  logic signed [TEMP_W-1:0] req_slot_setpoint,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_relay_on,
   output logic [OUT_W-1:0]         rsp_outcome,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_data
);

   logic                     enabled_ff;
   logic [MODE_W-1:0]        mode_ff;
   logic signed [TEMP_W-1:0] setpoint_ff;
   logic [BAND_W-1:0]        band_below_ff;
   logic [BAND_W-1:0]        band_above_ff;
   logic [LIMIT_W-1:0]       stale_limit_ff;

   logic                     csr_we;
   cfg_type                  cfg;
   item_type                 req_item;
   mem_wr_type               mem_wr;
   logic                     mem_rd_en;
   logic [ADDR_W-1:0]        mem_rd_addr;
   slot_type                 mem_rd_data;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff     <= 1'b0;
         mode_ff        <= MODE_MANUAL;
         setpoint_ff    <= TEMP_W'(2100);
         band_below_ff  <= '0;
         band_above_ff  <= '0;
         stale_limit_ff <= LIMIT_W'(6000);
      end else if (csr_we) begin
         case (csr_index)
            CSR_ENABLED: begin
               enabled_ff <= csr_data[0];
            end
            CSR_MODE: begin
               if (csr_data[MODE_W-1:0] <= MODE_RESERVED) begin
                  mode_ff <= csr_data[MODE_W-1:0];
               end
            end
            CSR_SETPOINT: begin
               setpoint_ff <= csr_data[TEMP_W-1:0];
            end
            CSR_BAND_BELOW: begin
               band_below_ff <= csr_data[BAND_W-1:0];
            end
            CSR_BAND_ABOVE: begin
               band_above_ff <= csr_data[BAND_W-1:0];
            end
            CSR_STALE_LIMIT: begin
               stale_limit_ff <= csr_data[LIMIT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cfg.enabled         = enabled_ff;
      cfg.mode            = mode_ff;
      cfg.manual_setpoint = setpoint_ff;
      cfg.band_below      = band_below_ff;
      cfg.band_above      = band_above_ff;
      cfg.stale_limit     = stale_limit_ff;
      cfg.relay_clear     = csr_we && (csr_index == CSR_ENABLED) && !csr_data[0];
   end

   always_comb begin
      req_item.kind          = req_kind;
      req_item.temperature   = req_temperature;
      req_item.sensor_active = req_sensor_active;
      req_item.sensor_age    = req_sensor_age;
      req_item.day_of_week   = req_day_of_week;
      req_item.hour          = req_hour;
      req_item.minute        = req_minute;
      req_item.slot_index    = req_slot_index;
      req_item.slot_active   = req_slot_active;
      req_item.slot_start    = req_slot_start;
      req_item.slot_end      = req_slot_end;
      req_item.slot_setpoint = req_slot_setpoint;
   end

   sht_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .wr      (mem_wr),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   sht_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_item     (req_item),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_relay_on (rsp_relay_on),
      .rsp_outcome  (rsp_outcome),
      .mem_wr       (mem_wr),
      .mem_rd_en    (mem_rd_en),
      .mem_rd_addr  (mem_rd_addr),
      .mem_rd_data  (mem_rd_data)
   );

   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("transaction accepted while another is in work");

   a_forced_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_outcome == OUT_STALE || rsp_outcome == OUT_INVALID))
      |-> !rsp_relay_on)
      else $error("relay on after stale or invalid sensor");

   a_cmp_drive: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_outcome == OUT_ON_LOW || rsp_outcome == OUT_OFF_HIGH))
      |-> (rsp_relay_on == (rsp_outcome == OUT_ON_LOW)))
      else $error("relay drive disagrees with compare outcome");

   a_write_no_read: assert property (@(posedge clock) disable iff (reset)
      !(mem_wr.en && mem_rd_en))
      else $error("slot store written and read in the same cycle");

endmodule
